@@ rtl/tsrt_pkg.sv @@
`default_nettype none

package tsrt_pkg;

    localparam int SPEED_W = 8;
    localparam int MIN_W   = 16;
    localparam int MS_W    = 32;

    // command codes of an input item
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [SPEED_W-1:0] DEFAULT_FALLBACK = 8'd42;
    localparam logic [MIN_W-1:0]   MS_PER_MINUTE    = 16'd60000;

    typedef struct packed {
        logic               cmd;
        logic [SPEED_W-1:0] request_speed;
        logic [MIN_W-1:0]   duration_minutes;
        logic               clears_queue;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic [SPEED_W-1:0] fan_speed;
        logic               speed_changed;
    } t_rsp;

    // one table entry as held in the entry ram
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [MS_W-1:0]    remaining_ms;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/tsrt_if.sv @@
`default_nettype none

// request channel
interface tsrt_req_if;
    import tsrt_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// result channel
interface tsrt_rsp_if;
    import tsrt_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tsrt_ram.sv @@
`default_nettype none

module tsrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/timed_speed_request_table.sv @@
`default_nettype none

// Table of ENTRIES timed fan speed requests. A request with zero duration sets
// the fallback speed (and empties the table when clears_queue is set); one with
// a duration takes the lowest free entry, or on a full table replaces the
// lowest-speed entry if its own speed is higher. A tick counts every active
// entry down by TICK_MS, frees expired entries and puts the highest active
// speed (or the fallback) in force. Items are taken one at a time: a
// zero-duration request goes straight to its result, any other item first
// walks the entry ram at one read per cycle. A result waits in an output
// register; a new item is taken as soon as the sequencer is back in idle.
// No clearing pass is needed after reset.
module timed_speed_request_table #(
    parameter int ENTRIES = 8,
    parameter int TICK_MS = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsrt_req_if.sink   i_req,
    tsrt_rsp_if.source o_rsp
);

    import tsrt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_ENTRIES = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [MS_W-1:0]  TICK_W      = MS_W'(TICK_MS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [ENTRIES-1:0] r_active;
    logic [SPEED_W-1:0] r_fallback;
    logic [SPEED_W-1:0] r_cur;
    logic               r_was_empty;

    // item held during the walk
    logic               r_is_tick;
    logic [SPEED_W-1:0] r_spd;
    logic [MS_W-1:0]    r_ms;

    // walk counters
    logic [CNT_W-1:0]   r_rd_cnt;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;

    // search results
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_have_min;
    logic [SPEED_W-1:0] r_min_spd;
    logic [IDX_W-1:0]   r_min_idx;
    logic               r_any;
    logic [SPEED_W-1:0] r_top;

    t_rsp               r_res;
    logic               r_out_valid;
    t_rsp               r_out_data;

    // ram ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;

    t_entry             cmp_word;
    logic               cmp_active;
    logic               cmp_keep;
    logic [MS_W-1:0]    cmp_rem;
    logic               cmp_last;
    logic               place;
    logic [IDX_W-1:0]   place_idx;
    logic [SPEED_W-1:0] n_cur;
    logic               in_fire;

    assign in_fire     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    // entry under compare, read out the cycle after its address
    assign cmp_word   = t_entry'(ram_rdata);
    assign cmp_active = r_active[r_cmp_idx];
    assign cmp_keep   = cmp_active && (cmp_word.remaining_ms > TICK_W);
    assign cmp_rem    = cmp_word.remaining_ms - TICK_W;
    assign cmp_last   = r_cmp_vld && (r_cmp_idx == LAST_IDX);

    // placement decision once the walk is over
    assign place     = r_free_found || (r_have_min && (r_min_spd < r_spd));
    assign place_idx = r_free_found ? r_free_idx : r_min_idx;
    assign n_cur     = r_any ? r_top : r_fallback;

    // read side walks the table
    assign ram_re    = (r_state == S_WALK) && (r_rd_cnt < CNT_ENTRIES);
    assign ram_raddr = r_rd_cnt[IDX_W-1:0];

    // write side: count-down write-back on a tick, new entry on a request
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = '{speed: cmp_word.speed, remaining_ms: cmp_rem};
        if (r_state == S_WALK && r_is_tick && r_cmp_vld && cmp_keep) begin
            ram_we = 1'b1;
        end else if (r_state == S_FINISH && !r_is_tick && place) begin
            ram_we    = 1'b1;
            ram_waddr = place_idx;
            ram_wdata = '{speed: r_spd, remaining_ms: r_ms};
        end
    end

    tsrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // sequencer, table state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_fallback  <= DEFAULT_FALLBACK;
            r_cur       <= '0;
            r_was_empty <= 1'b1;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_rd_cnt    <= '0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_vld <= ram_re;
            r_cmp_idx <= ram_raddr;
            if (ram_re) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_is_tick    <= (i_req.data.cmd == CMD_TICK);
                        r_spd        <= i_req.data.request_speed;
                        r_ms         <= MS_W'(i_req.data.duration_minutes) *
                                        MS_W'(MS_PER_MINUTE);
                        r_rd_cnt     <= '0;
                        r_free_found <= 1'b0;
                        r_have_min   <= 1'b0;
                        r_any        <= 1'b0;
                        r_top        <= '0;
                        if (i_req.data.cmd == CMD_TICK ||
                            i_req.data.duration_minutes != '0) begin
                            r_state <= S_WALK;
                        end else begin
                            // zero duration: new fallback, optional clear
                            r_fallback <= i_req.data.request_speed;
                            if (i_req.data.clears_queue) begin
                                r_active <= '0;
                            end
                            r_res   <= '{accepted: 1'b1, fan_speed: r_cur,
                                         speed_changed: 1'b0};
                            r_state <= S_DONE;
                        end
                    end
                end

                S_WALK: begin
                    if (r_cmp_vld) begin
                        if (r_is_tick) begin
                            // count down, free expired, track the top speed
                            if (!cmp_keep) begin
                                r_active[r_cmp_idx] <= 1'b0;
                            end else begin
                                r_any <= 1'b1;
                                if (cmp_word.speed > r_top) begin
                                    r_top <= cmp_word.speed;
                                end
                            end
                        end else begin
                            // first free entry and lowest-speed entry
                            if (!cmp_active) begin
                                if (!r_free_found) begin
                                    r_free_found <= 1'b1;
                                    r_free_idx   <= r_cmp_idx;
                                end
                            end else if (!r_have_min || cmp_word.speed < r_min_spd) begin
                                r_have_min <= 1'b1;
                                r_min_spd  <= cmp_word.speed;
                                r_min_idx  <= r_cmp_idx;
                            end
                        end
                    end
                    if (cmp_last) begin
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    if (r_is_tick) begin
                        if (!r_any) begin
                            r_was_empty <= 1'b1;
                        end else if (r_was_empty) begin
                            r_was_empty <= 1'b0;
                            r_fallback  <= r_cur;
                        end
                        r_cur <= n_cur;
                        r_res <= '{accepted: 1'b0, fan_speed: n_cur,
                                   speed_changed: (n_cur != r_cur)};
                    end else begin
                        if (place) begin
                            r_active[place_idx] <= 1'b1;
                        end
                        r_res <= '{accepted: place, fan_speed: r_cur,
                                   speed_changed: 1'b0};
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // hand the result over once the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // the read walk never runs past the table
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= CNT_ENTRIES)
        else $error("entry walk ran past the table");

    // a request walk only reads, the ram is written at its end
    a_req_walk_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !r_is_tick) |-> !ram_we)
        else $error("ram written during a request search");

    // a tick never reports an accepted request
    a_tick_not_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_is_tick) |=> !r_res.accepted)
        else $error("tick reported as accepted");

    // an empty table after a tick runs at the fallback speed
    a_empty_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_is_tick && !r_any) |=>
            (r_cur == r_fallback && r_was_empty))
        else $error("empty table not at fallback speed");

    // a clearing zero-duration request empties every entry
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.data.cmd == CMD_REQUEST &&
         i_req.data.duration_minutes == '0 && i_req.data.clears_queue) |=>
            (r_active == '0))
        else $error("table not emptied by clear");
`endif

endmodule

`default_nettype wire

@@ tb/sv/timed_speed_request_table_test.sv @@
`default_nettype none

module timed_speed_request_table_test;
    import tsrt_pkg::*;

    localparam int ENTRIES          = 8;
    localparam int TICK_MS          = 10;
    localparam int CLK_PERIOD       = 8;
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    // longest walk over the entry ram plus some margin
    localparam int SETTLE_CYCLES    = ENTRIES + 12;

    // one row of the directed stimulus
    typedef struct {
        t_req item;
        bit   fixed;
        t_rsp want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsrt_req_if req_ch ();
    tsrt_rsp_if rsp_ch ();

    timed_speed_request_table #(
        .ENTRIES(ENTRIES),
        .TICK_MS(TICK_MS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // predicted table contents
    logic [SPEED_W-1:0] tbl_speed   [ENTRIES];
    bit                 tbl_live    [ENTRIES];
    logic [MS_W-1:0]    tbl_left_ms [ENTRIES];
    logic [SPEED_W-1:0] fallback_lvl;
    logic [SPEED_W-1:0] level_in_force;
    bit                 was_empty;

    t_rsp speed_reports_due[$];
    t_row stim_rows[$];
    int   fail_count = 0;
    bit   send_quiet = 1'b0;
    bit   recv_quiet = 1'b0;

    // clock
    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic void empty_speed_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_speed[i]   = '0;
            tbl_live[i]    = 1'b0;
            tbl_left_ms[i] = '0;
        end
    endfunction

    // apply one item to the predicted table and give the report it causes
    function automatic t_rsp speed_table_step(input t_req item);
        t_rsp               res;
        logic [MS_W-1:0]    span_ms;
        logic [SPEED_W-1:0] top;
        logic [SPEED_W-1:0] prior;
        bit                 any;
        bit                 placed;
        int                 low;
        res = '0;
        if (item.cmd == CMD_TICK) begin
            prior = level_in_force;
            any   = 1'b0;
            top   = '0;
            // count down, free expired entries, find the top speed
            for (int i = 0; i < ENTRIES; i++) begin
                if (tbl_left_ms[i] > MS_W'(TICK_MS)) begin
                    tbl_left_ms[i] = tbl_left_ms[i] - MS_W'(TICK_MS);
                end else begin
                    tbl_left_ms[i] = '0;
                end
                if (tbl_left_ms[i] == '0) begin
                    tbl_live[i]  = 1'b0;
                    tbl_speed[i] = '0;
                end
                if (tbl_live[i]) begin
                    if (!any || tbl_speed[i] > top) begin
                        top = tbl_speed[i];
                    end
                    any = 1'b1;
                end
            end
            if (!any) begin
                was_empty      = 1'b1;
                level_in_force = fallback_lvl;
            end else begin
                // table just occupied: speed in force becomes the fallback
                if (was_empty) begin
                    was_empty    = 1'b0;
                    fallback_lvl = level_in_force;
                end
                level_in_force = top;
            end
            res.speed_changed = (level_in_force != prior);
        end else if (item.duration_minutes == '0) begin
            fallback_lvl = item.request_speed;
            if (item.clears_queue) begin
                empty_speed_table();
            end
            res.accepted = 1'b1;
        end else begin
            span_ms = MS_W'(item.duration_minutes) * MS_W'(MS_PER_MINUTE);
            placed  = 1'b0;
            // lowest free entry first
            for (int i = 0; i < ENTRIES; i++) begin
                if (!placed && !tbl_live[i]) begin
                    tbl_live[i]    = 1'b1;
                    tbl_speed[i]   = item.request_speed;
                    tbl_left_ms[i] = span_ms;
                    placed         = 1'b1;
                end
            end
            // full table: replace the slowest entry if strictly slower
            if (!placed) begin
                low = 0;
                for (int i = 1; i < ENTRIES; i++) begin
                    if (tbl_speed[i] < tbl_speed[low]) begin
                        low = i;
                    end
                end
                if (tbl_speed[low] < item.request_speed) begin
                    tbl_speed[low]   = item.request_speed;
                    tbl_left_ms[low] = span_ms;
                    placed           = 1'b1;
                end
            end
            res.accepted = placed;
        end
        res.fan_speed = level_in_force;
        return res;
    endfunction

    function automatic t_req mk_req(input logic cmd, input logic [SPEED_W-1:0] spd,
                                    input logic [MIN_W-1:0] mins, input logic clr);
        t_req r;
        r.cmd              = cmd;
        r.request_speed    = spd;
        r.duration_minutes = mins;
        r.clears_queue     = clr;
        return r;
    endfunction

    function automatic void add_row(input logic cmd, input logic [SPEED_W-1:0] spd,
                                    input logic [MIN_W-1:0] mins, input logic clr,
                                    input bit fixed, input logic acc,
                                    input logic [SPEED_W-1:0] lvl, input logic chg);
        t_row row;
        row.item                = mk_req(cmd, spd, mins, clr);
        row.fixed               = fixed;
        row.want.accepted       = acc;
        row.want.fan_speed      = lvl;
        row.want.speed_changed  = chg;
        stim_rows.push_back(row);
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < 10) begin
            $display("%s", msg);
        end
        fail_count++;
    endfunction

    // drive one item from a falling edge; returns at a falling edge
    task automatic send_item(input t_req item, input bit fixed, input t_rsp want);
        int   gap;
        t_rsp predicted;
        if ($urandom_range(0, 39) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : int'($urandom_range(0, 5));
        repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = speed_table_step(item);
        speed_reports_due.push_back(fixed ? want : predicted);
        @(negedge i_clk);
    endtask

    // hold the sender back until every report is in
    task automatic drain_reports();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (speed_reports_due.size() != 0);
    endtask

    // result side: random stalls, check each report against the oldest due
    initial begin
        int   stall;
        t_rsp due;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                recv_quiet = !recv_quiet;
            end
            stall = recv_quiet ? 0 : int'($urandom_range(0, 5));
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            if (speed_reports_due.size() == 0) begin
                note_failure($sformatf("unexpected report: acc=%0d speed=%0d chg=%0d",
                                       rsp_ch.data.accepted, rsp_ch.data.fan_speed,
                                       rsp_ch.data.speed_changed));
            end else begin
                due = speed_reports_due.pop_front();
                if (rsp_ch.data.accepted !== due.accepted
                        || rsp_ch.data.fan_speed !== due.fan_speed
                        || rsp_ch.data.speed_changed !== due.speed_changed) begin
                    note_failure($sformatf(
                        "report mismatch: acc exp %0d got %0d, speed exp %0d got %0d, chg exp %0d got %0d",
                        due.accepted, rsp_ch.data.accepted, due.fan_speed,
                        rsp_ch.data.fan_speed, due.speed_changed,
                        rsp_ch.data.speed_changed));
                end
            end
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int r;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        empty_speed_table();
        fallback_lvl   = DEFAULT_FALLBACK;
        level_in_force = '0;
        was_empty      = 1'b1;

        // directed rows: cmd, speed, minutes, clear, fixed, acc, speed, changed
        // empty table after reset: default fallback comes into force
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd42,  1'b1);
        add_row(CMD_TICK,    8'd255, 16'hFFFF,   1'b1, 1'b1, 1'b0, 8'd42,  1'b0);
        // zero duration without clear touches only the fallback
        add_row(CMD_REQUEST, 8'd255, 16'd0,      1'b0, 1'b1, 1'b1, 8'd42,  1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd255, 1'b1);
        add_row(CMD_REQUEST, 8'd0,   16'd0,      1'b1, 1'b1, 1'b1, 8'd255, 1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd0,   1'b1);
        // first entry, then the table goes from empty to occupied
        add_row(CMD_REQUEST, 8'd200, 16'hFFFF,   1'b0, 1'b1, 1'b1, 8'd0,   1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd200, 1'b1);
        // fill the table
        add_row(CMD_REQUEST, 8'd0,   16'd1,      1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        add_row(CMD_REQUEST, 8'd10,  16'h5555,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        add_row(CMD_REQUEST, 8'd20,  16'hAAAA,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        add_row(CMD_REQUEST, 8'd30,  16'h0100,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        add_row(CMD_REQUEST, 8'd40,  16'h8000,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        add_row(CMD_REQUEST, 8'd50,  16'h00FF,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        add_row(CMD_REQUEST, 8'd60,  16'd2,      1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
        // full table: equal speed dropped, higher speeds replace the slowest
        add_row(CMD_REQUEST, 8'd0,   16'd5,      1'b0, 1'b1, 1'b0, 8'd200, 1'b0);
        add_row(CMD_REQUEST, 8'd1,   16'd3,      1'b0, 1'b1, 1'b1, 8'd200, 1'b0);
        add_row(CMD_REQUEST, 8'd255, 16'hFFFF,   1'b0, 1'b1, 1'b1, 8'd200, 1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd255, 1'b1);
        add_row(CMD_REQUEST, 8'd77,  16'd0,      1'b0, 1'b1, 1'b1, 8'd255, 1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd255, 1'b0);
        // clear, then a timed request with the clear bit set (ignored)
        add_row(CMD_REQUEST, 8'd128, 16'd0,      1'b1, 1'b1, 1'b1, 8'd255, 1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd128, 1'b1);
        add_row(CMD_REQUEST, 8'd9,   16'h8000,   1'b1, 1'b1, 1'b1, 8'd128, 1'b0);
        add_row(CMD_TICK,    8'd0,   16'd0,      1'b0, 1'b1, 1'b0, 8'd9,   1'b1);

        // synchronous reset
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[k]) begin
            send_item(stim_rows[k].item, stim_rows[k].fixed, stim_rows[k].want);
        end
        drain_reports();

        // random mix of ticks, timed requests, fallback changes and clears
        for (int n = 0; n < 800; n++) begin
            if (n == 400 || $urandom_range(0, 99) == 0) begin
                drain_reports();
            end
            r = int'($urandom_range(0, 99));
            if (r < 45) begin
                send_item(mk_req(CMD_TICK, SPEED_W'($urandom_range(0, 255)),
                                 MIN_W'($urandom_range(0, 65535)),
                                 1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (r < 57) begin
                send_item(mk_req(CMD_REQUEST, SPEED_W'($urandom_range(0, 255)), '0,
                                 1'($urandom_range(0, 2) == 0)), 1'b0, '0);
            end else begin
                send_item(mk_req(CMD_REQUEST, SPEED_W'($urandom_range(0, 255)),
                                 MIN_W'($urandom_range(1, 65535)),
                                 1'($urandom_range(0, 1))), 1'b0, '0);
            end
        end
        drain_reports();

        // wind down
        req_ch.valid <= 1'b0;
        while (speed_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/tsrt_pkg.sv
rtl/tsrt_if.sv
rtl/tsrt_ram.sv
rtl/timed_speed_request_table.sv
tb/sv/timed_speed_request_table_test.sv
